FILE: design/bbp_pkg.sv
// Shared types and constants for the bicubic Bezier patch evaluator.
`default_nettype none

package bbp_pkg;

    // Defaults for the top-level parameters
    localparam int MAX_GRID_DEF   = 64;
    localparam int COORD_BITS_DEF = 16;

    // Fixed field widths
    localparam int SLOT_W = 4;            // control point slot
    localparam int NUM_CP = 1 << SLOT_W;  // 4x4 grid
    localparam int GRID_W = 6;            // grid row / column
    localparam int STEP_W = 16;           // grid_step, Q1.15
    localparam int W_W    = 16;           // Bernstein and patch weights, Q1.15

    localparam logic [STEP_W-1:0] STEP_RESET = 16'd2048;
    localparam logic [STEP_W-1:0] ONE_Q15    = 16'h8000;

    // Item kinds carried on s_tuser
    typedef enum logic {
        OP_LOAD = 1'b0,
        OP_EVAL = 1'b1
    } opcode_t;

    // Four Bernstein weights, index 0 = (1-s)^3
    typedef logic [3:0][W_W-1:0] weights_t;

    // Status of a sequenced unit
    typedef struct packed {
        logic busy;
        logic done;
    } unit_status_t;

endpackage

`default_nettype wire

FILE: design/bbp_weight_unit.sv
// Bernstein weight generator: one shared multiplier stepped through 16 products.
`default_nettype none

module bbp_weight_unit
    import bbp_pkg::*;
#(
    parameter int MAX_GRID = MAX_GRID_DEF
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              start,
    input  wire logic [GRID_W-1:0] row,
    input  wire logic [GRID_W-1:0] col,
    input  wire logic [STEP_W-1:0] grid_step,
    output weights_t               bt,
    output weights_t               bv,
    output unit_status_t           status
);

    localparam int IDX_W = ($clog2(MAX_GRID) > GRID_W) ? $clog2(MAX_GRID) : GRID_W;
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(MAX_GRID - 1);
    localparam int MA_W = 32;
    localparam int P_W  = MA_W + STEP_W;
    localparam logic [P_W-1:0] RND30 = P_W'(1) << 29;

    // Product schedule for one parameter
    typedef enum logic [2:0] {
        WS_PARAM = 3'd0,   // s = idx * step
        WS_SS    = 3'd1,
        WS_UU    = 3'd2,
        WS_SU    = 3'd3,
        WS_B3    = 3'd4,
        WS_B0    = 3'd5,
        WS_B1    = 3'd6,
        WS_B2    = 3'd7
    } wstep_t;

    wstep_t            wstep_reg;
    logic              bank_reg;      // 0: t from row, 1: v from col
    logic              busy_reg;
    logic              done_reg;
    logic [STEP_W-1:0] s_reg;
    logic [STEP_W-1:0] u_reg;
    logic [30:0]       ss_reg;
    logic [30:0]       uu_reg;
    logic [31:0]       su3_reg;
    weights_t          bt_reg;
    weights_t          bv_reg;

    logic [IDX_W-1:0]  idx_raw;
    logic [IDX_W-1:0]  idx_clamped;
    logic [MA_W-1:0]   mul_a;
    logic [STEP_W-1:0] mul_b;
    logic [P_W-1:0]    prod;
    logic [P_W-1:0]    prod_rnd;
    logic [W_W-1:0]    b_val;
    logic [STEP_W-1:0] s_val;
    logic              last_step;

    // Sample index, clamped to the grid
    always_comb begin
        idx_raw     = bank_reg ? IDX_W'(col) : IDX_W'(row);
        idx_clamped = (idx_raw > IDX_LAST) ? IDX_LAST : idx_raw;
    end

    // Operand select for the shared multiplier
    always_comb begin
        case (wstep_reg)
            WS_PARAM: begin
                mul_a = MA_W'(idx_clamped);
                mul_b = grid_step;
            end
            WS_SS: begin
                mul_a = MA_W'(s_reg);
                mul_b = s_reg;
            end
            WS_UU: begin
                mul_a = MA_W'(u_reg);
                mul_b = u_reg;
            end
            WS_SU: begin
                mul_a = MA_W'(s_reg);
                mul_b = u_reg;
            end
            WS_B3: begin
                mul_a = MA_W'(ss_reg);
                mul_b = s_reg;
            end
            WS_B0: begin
                mul_a = MA_W'(uu_reg);
                mul_b = u_reg;
            end
            WS_B1: begin
                mul_a = su3_reg;
                mul_b = u_reg;
            end
            WS_B2: begin
                mul_a = su3_reg;
                mul_b = s_reg;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb begin
        prod      = P_W'(mul_a) * P_W'(mul_b);
        prod_rnd  = prod + RND30;
        b_val     = prod_rnd[30 +: W_W];
        s_val     = (prod > P_W'(ONE_Q15)) ? ONE_Q15 : prod[STEP_W-1:0];
        last_step = bank_reg && (wstep_reg == WS_B2);
    end

    // Sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            bank_reg  <= 1'b0;
            wstep_reg <= WS_PARAM;
        end else begin
            done_reg <= busy_reg && last_step;
            if (start) begin
                busy_reg  <= 1'b1;
                bank_reg  <= 1'b0;
                wstep_reg <= WS_PARAM;
            end else if (busy_reg) begin
                wstep_reg <= wstep_t'(wstep_reg + 3'd1);
                if (wstep_reg == WS_B2) begin
                    bank_reg <= 1'b1;
                end
                if (last_step) begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    // Intermediate products and weight banks
    always_ff @(posedge aclk) begin
        if (busy_reg) begin
            case (wstep_reg)
                WS_PARAM: begin
                    s_reg <= s_val;
                    u_reg <= ONE_Q15 - s_val;
                end
                WS_SS: ss_reg <= prod[30:0];
                WS_UU: uu_reg <= prod[30:0];
                WS_SU: su3_reg <= prod[31:0] + {prod[30:0], 1'b0};
                WS_B3: begin
                    if (bank_reg) bv_reg[3] <= b_val;
                    else          bt_reg[3] <= b_val;
                end
                WS_B0: begin
                    if (bank_reg) bv_reg[0] <= b_val;
                    else          bt_reg[0] <= b_val;
                end
                WS_B1: begin
                    if (bank_reg) bv_reg[1] <= b_val;
                    else          bt_reg[1] <= b_val;
                end
                WS_B2: begin
                    if (bank_reg) bv_reg[2] <= b_val;
                    else          bt_reg[2] <= b_val;
                end
                default: begin
                end
            endcase
        end
    end

    assign bt          = bt_reg;
    assign bv          = bv_reg;
    assign status.busy = busy_reg;
    assign status.done = done_reg;

endmodule

`default_nettype wire

FILE: design/bbp_mac.sv
// Control point store and multiply-accumulate pass over the 4x4 grid.
`default_nettype none

module bbp_mac
    import bbp_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       wr_en,
    input  wire logic [SLOT_W-1:0]          wr_slot,
    input  wire logic [2:0][COORD_BITS-1:0] wr_xyz,
    input  wire logic                       start,
    input  wire weights_t                   bt,
    input  wire weights_t                   bv,
    output logic [2:0][COORD_BITS-1:0]      sum_xyz,
    output unit_status_t                    status
);

    localparam int PR_W  = COORD_BITS + W_W + 1;
    localparam int ACC_W = PR_W + SLOT_W;
    localparam int RS_W  = ACC_W - 15;
    localparam int CNT_W = SLOT_W + 1;
    localparam logic [ACC_W-1:0] HALF_LSB = ACC_W'(1) << 14;

    logic [2:0][COORD_BITS-1:0] store_reg [NUM_CP];
    logic signed [COORD_BITS-1:0] cp_reg [3];
    logic signed [ACC_W-1:0]      acc_reg [3];
    logic [W_W-1:0]               w_reg;
    logic                         pvalid_reg;
    logic [CNT_W-1:0]             cnt_reg;
    logic                         busy_reg;
    logic                         done_reg;

    logic [SLOT_W-1:0]            slot;
    logic                         issue;
    logic [2*W_W-1:0]             wp;
    logic [2*W_W-1:0]             wp_rnd;
    logic signed [PR_W-1:0]       prod [3];

    always_comb begin
        slot   = cnt_reg[SLOT_W-1:0];
        issue  = busy_reg && !cnt_reg[SLOT_W];
        // Patch weight Bv[row] * Bt[col], rounded to Q1.15
        wp     = (2*W_W)'(bv[slot[SLOT_W-1:2]]) * (2*W_W)'(bt[slot[1:0]]);
        wp_rnd = wp + (2*W_W)'(1 << 14);
        for (int k = 0; k < 3; k++) begin
            prod[k] = cp_reg[k] * $signed({1'b0, w_reg});
        end
    end

    // Control point store, cleared by reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_CP; i++) begin
                store_reg[i] <= '0;
            end
        end else if (wr_en) begin
            store_reg[wr_slot] <= wr_xyz;
        end
    end

    // Pass control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg   <= 1'b0;
            done_reg   <= 1'b0;
            pvalid_reg <= 1'b0;
            cnt_reg    <= '0;
        end else begin
            done_reg   <= busy_reg && cnt_reg[SLOT_W];
            pvalid_reg <= issue;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                if (cnt_reg[SLOT_W]) begin
                    busy_reg <= 1'b0;
                end else begin
                    cnt_reg <= cnt_reg + CNT_W'(1);
                end
            end
        end
    end

    // Weight / operand stage, then accumulate
    always_ff @(posedge aclk) begin
        if (issue) begin
            w_reg <= wp_rnd[15 +: W_W];
            for (int k = 0; k < 3; k++) begin
                cp_reg[k] <= $signed(store_reg[slot][k]);
            end
        end
        if (start) begin
            for (int k = 0; k < 3; k++) begin
                acc_reg[k] <= '0;
            end
        end else if (pvalid_reg) begin
            for (int k = 0; k < 3; k++) begin
                acc_reg[k] <= acc_reg[k] + ACC_W'(prod[k]);
            end
        end
    end

    // Round half up, then saturate to the coordinate range
    always_comb begin
        logic [ACC_W-1:0] rs_full;
        logic [RS_W-1:0]  rs;
        logic             fits;
        for (int k = 0; k < 3; k++) begin
            rs_full = acc_reg[k] + HALF_LSB;
            rs      = rs_full[ACC_W-1:15];
            fits    = (&rs[RS_W-1:COORD_BITS-1]) || !(|rs[RS_W-1:COORD_BITS-1]);
            if (fits) begin
                sum_xyz[k] = rs[COORD_BITS-1:0];
            end else if (rs[RS_W-1]) begin
                sum_xyz[k] = {1'b1, {(COORD_BITS-1){1'b0}}};
            end else begin
                sum_xyz[k] = {1'b0, {(COORD_BITS-1){1'b1}}};
            end
        end
    end

    assign status.busy = busy_reg;
    assign status.done = done_reg;

endmodule

`default_nettype wire

FILE: design/bicubic_bezier_patch_eval.sv
// Top level of the bicubic Bezier patch evaluator: handshakes and item sequencing.
// An evaluate holds s_tready low until its result is written to the output register;
// loads are taken back to back while idle. An evaluate runs 16 steps of the shared weight
// multiplier, then a multiply-accumulate pass over the 16 control points.
// Reset (aresetn low, synchronous): control points zero, grid_step 2048, output empty.
`default_nettype none

module bicubic_bezier_patch_eval
    import bbp_pkg::*;
#(
    parameter int MAX_GRID   = MAX_GRID_DEF,
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    // point_index, coord_x, coord_y, coord_z, grid_row, grid_col
    input  wire logic [((SLOT_W + 3*COORD_BITS + 2*GRID_W + 7)/8)*8-1:0] s_tdata,
    // opcode
    input  wire logic                         s_tuser,
    input  wire logic                         s_tvalid,
    output logic                              s_tready,
    input  wire logic [STEP_W-1:0]            cfg_data,
    input  wire logic                         cfg_valid,
    output logic                              cfg_ready,
    // surf_x, surf_y, surf_z, out_row, out_col
    output logic [((3*COORD_BITS + 2*GRID_W + 7)/8)*8-1:0] m_tdata,
    output logic                              m_tvalid,
    input  wire logic                         m_tready
);

    localparam int OUT_W   = ((3*COORD_BITS + 2*GRID_W + 7)/8)*8;
    localparam int IN_ROW  = SLOT_W + 3*COORD_BITS;
    localparam int IN_COL  = IN_ROW + GRID_W;
    localparam int OUT_ROW = 3*COORD_BITS;
    localparam int OUT_COL = OUT_ROW + GRID_W;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_WEIGHT = 4'b0010,
        ST_MAC    = 4'b0100,
        ST_HOLD   = 4'b1000
    } state_t;

    state_t            state_reg;
    state_t            state_next;
    logic [STEP_W-1:0] grid_step_reg;
    logic [GRID_W-1:0] row_reg;
    logic [GRID_W-1:0] col_reg;
    logic              m_valid_reg;
    logic [OUT_W-1:0]  m_data_reg;
    logic [OUT_W-1:0]  m_data_next;

    opcode_t                    op;
    logic                       s_accept;
    logic                       ld_en;
    logic                       ev_start;
    logic                       mac_start;
    logic                       out_free;
    logic                       out_write;
    logic [2:0][COORD_BITS-1:0] in_xyz;
    logic [2:0][COORD_BITS-1:0] sum_xyz;
    weights_t                   bt;
    weights_t                   bv;
    unit_status_t               w_st;
    unit_status_t               mac_st;

    // Input transaction decode
    always_comb begin
        s_tready = (state_reg == ST_IDLE);
        s_accept = s_tvalid && s_tready;
        op       = opcode_t'(s_tuser);
        ld_en    = s_accept && (op == OP_LOAD);
        ev_start = s_accept && (op == OP_EVAL);
        for (int k = 0; k < 3; k++) begin
            in_xyz[k] = s_tdata[SLOT_W + k*COORD_BITS +: COORD_BITS];
        end
    end

    assign cfg_ready = 1'b1;

    // Configuration register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            grid_step_reg <= STEP_RESET;
        end else if (cfg_valid && cfg_ready) begin
            grid_step_reg <= cfg_data;
        end
    end

    // Evaluate coordinates, echoed on the result
    always_ff @(posedge aclk) begin
        if (ev_start) begin
            row_reg <= s_tdata[IN_ROW +: GRID_W];
            col_reg <= s_tdata[IN_COL +: GRID_W];
        end
    end

    // Sequencer
    always_comb begin
        out_free   = !m_valid_reg || m_tready;
        mac_start  = (state_reg == ST_WEIGHT) && w_st.done;
        out_write  = 1'b0;
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (ev_start) state_next = ST_WEIGHT;
            end
            ST_WEIGHT: begin
                if (w_st.done) state_next = ST_MAC;
            end
            ST_MAC: begin
                if (mac_st.done) begin
                    if (out_free) begin
                        out_write  = 1'b1;
                        state_next = ST_IDLE;
                    end else begin
                        state_next = ST_HOLD;
                    end
                end
            end
            ST_HOLD: begin
                if (out_free) begin
                    out_write  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Output register
    always_comb begin
        m_data_next = '0;
        for (int k = 0; k < 3; k++) begin
            m_data_next[k*COORD_BITS +: COORD_BITS] = sum_xyz[k];
        end
        m_data_next[OUT_ROW +: GRID_W] = row_reg;
        m_data_next[OUT_COL +: GRID_W] = col_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_write) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_write) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    bbp_weight_unit #(
        .MAX_GRID (MAX_GRID)
    ) u_weight (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (ev_start),
        .row       (row_reg),
        .col       (col_reg),
        .grid_step (grid_step_reg),
        .bt        (bt),
        .bv        (bv),
        .status    (w_st)
    );

    bbp_mac #(
        .COORD_BITS (COORD_BITS)
    ) u_mac (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (ld_en),
        .wr_slot (s_tdata[SLOT_W-1:0]),
        .wr_xyz  (in_xyz),
        .start   (mac_start),
        .bt      (bt),
        .bv      (bv),
        .sum_xyz (sum_xyz),
        .status  (mac_st)
    );

    // Weight generation and accumulation never overlap
    a_units_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        !(w_st.busy && mac_st.busy))
        else $error("weight unit and MAC busy together");

    // No new transaction while an evaluation is in flight
    a_busy_not_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        (w_st.busy || mac_st.busy) |-> !s_tready)
        else $error("s_tready high during evaluation");

    // Weights finished hands straight over to the MAC pass
    a_weight_to_mac: assert property (@(posedge aclk) disable iff (!aresetn)
        w_st.done |=> mac_st.busy)
        else $error("MAC pass did not start after weights");

    // A load never produces a result
    a_load_no_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && (op == OP_LOAD) && !m_tvalid) |=> !m_tvalid)
        else $error("result raised by a load transaction");

endmodule

`default_nettype wire

FILE: test/tb_bicubic_bezier_patch_eval.sv
// Self-checking testbench for the bicubic Bezier patch evaluator.
`timescale 1ns / 1ps

module tb_bicubic_bezier_patch_eval
    import bbp_pkg::*;
();

    localparam int CW          = COORD_BITS_DEF;
    localparam int S_W         = ((SLOT_W + 3*CW + 2*GRID_W + 7)/8)*8;
    localparam int M_W         = ((3*CW + 2*GRID_W + 7)/8)*8;
    localparam int DRAIN_WAIT  = 40;    // idle margin after the queues empty
    localparam int QUIET_LIMIT = 3000;
    localparam longint ONE     = 32768;

    typedef struct {
        opcode_t             op;
        logic [SLOT_W-1:0]   slot;
        logic [CW-1:0]       x;
        logic [CW-1:0]       y;
        logic [CW-1:0]       z;
        logic [GRID_W-1:0]   row;
        logic [GRID_W-1:0]   col;
    } patch_cmd_t;

    typedef struct {
        logic [CW-1:0]       x;
        logic [CW-1:0]       y;
        logic [CW-1:0]       z;
        logic [GRID_W-1:0]   row;
        logic [GRID_W-1:0]   col;
    } surf_point_t;

    logic              aclk      = 1'b0;
    logic              aresetn   = 1'b0;
    logic [S_W-1:0]    s_tdata   = '0;
    logic              s_tuser   = 1'b0;
    logic              s_tvalid  = 1'b0;
    logic              s_tready;
    logic [STEP_W-1:0] cfg_data  = '0;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [M_W-1:0]    m_tdata;
    logic              m_tvalid;
    logic              m_tready  = 1'b0;

    // Predictor state: control grid and step register
    logic signed [CW-1:0] cp_x [NUM_CP];
    logic signed [CW-1:0] cp_y [NUM_CP];
    logic signed [CW-1:0] cp_z [NUM_CP];
    logic [STEP_W-1:0]    step_reg = STEP_RESET;

    patch_cmd_t  pending_cmds [$];
    surf_point_t expected_points [$];
    patch_cmd_t  bus_cmd;
    surf_point_t want_pt;

    int src_idle_pct   = 0;
    int sink_stall_pct = 0;
    int err_count      = 0;
    int quiet_cycles   = 0;

    bicubic_bezier_patch_eval u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .cfg_data  (cfg_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .m_tdata   (m_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    initial begin
        for (int i = 0; i < NUM_CP; i++) begin
            cp_x[i] = '0;
            cp_y[i] = '0;
            cp_z[i] = '0;
        end
    end

    task automatic report_mismatch(input string msg);
        err_count++;
        $display("[%0t] ERROR: %s", $time, msg);
    endtask

    // Cubic Bernstein weight k at sample idx, Q1.15
    function automatic longint bern_weight(input int k, input logic [GRID_W-1:0] idx);
        longint s;
        longint u;
        longint p;
        s = longint'(idx) * longint'(step_reg);
        if (s > ONE)
            s = ONE;
        u = ONE - s;
        case (k)
            0:       p = u * u * u;
            1:       p = 3 * s * u * u;
            2:       p = 3 * s * s * u;
            default: p = s * s * s;
        endcase
        return (p + (longint'(1) << 29)) >>> 30;
    endfunction

    // Round half up from Q8.23 and saturate to Q8.8
    function automatic logic [CW-1:0] round_sat(input longint acc);
        longint v;
        v = (acc + 16384) >>> 15;
        if (v > 32767)
            v = 32767;
        if (v < -32768)
            v = -32768;
        return v[CW-1:0];
    endfunction

    function automatic surf_point_t eval_patch(input logic [GRID_W-1:0] row,
                                               input logic [GRID_W-1:0] col);
        longint      acc_x;
        longint      acc_y;
        longint      acc_z;
        longint      w;
        int          r;
        int          c;
        surf_point_t res;
        acc_x = 0;
        acc_y = 0;
        acc_z = 0;
        // t comes from the row, v from the column
        for (r = 0; r < 4; r++) begin
            for (c = 0; c < 4; c++) begin
                w = (bern_weight(r, col) * bern_weight(c, row) + 16384) >>> 15;
                acc_x += longint'(cp_x[r*4+c]) * w;
                acc_y += longint'(cp_y[r*4+c]) * w;
                acc_z += longint'(cp_z[r*4+c]) * w;
            end
        end
        res.x   = round_sat(acc_x);
        res.y   = round_sat(acc_y);
        res.z   = round_sat(acc_z);
        res.row = row;
        res.col = col;
        return res;
    endfunction

    // Stimulus builders; ignored fields always carry random bits
    function automatic void push_load(input int slot, input logic [CW-1:0] x,
                                      input logic [CW-1:0] y, input logic [CW-1:0] z);
        patch_cmd_t cmd;
        cmd.op   = OP_LOAD;
        cmd.slot = slot[SLOT_W-1:0];
        cmd.x    = x;
        cmd.y    = y;
        cmd.z    = z;
        cmd.row  = GRID_W'($urandom);
        cmd.col  = GRID_W'($urandom);
        pending_cmds.insert(pending_cmds.size(), cmd);
    endfunction

    function automatic void push_eval(input int row, input int col);
        patch_cmd_t cmd;
        cmd.op   = OP_EVAL;
        cmd.slot = SLOT_W'($urandom);
        cmd.x    = CW'($urandom);
        cmd.y    = CW'($urandom);
        cmd.z    = CW'($urandom);
        cmd.row  = row[GRID_W-1:0];
        cmd.col  = col[GRID_W-1:0];
        pending_cmds.insert(pending_cmds.size(), cmd);
    endfunction

    function automatic logic [CW-1:0] pick_coord();
        if ($urandom_range(99) < 20) begin
            case ($urandom_range(3))
                0:       return 16'h7FFF;
                1:       return 16'h8000;
                2:       return 16'h0000;
                default: return 16'hFFFF;
            endcase
        end
        return CW'($urandom);
    endfunction

    // Mix of single items and complete patches followed by evaluations
    task automatic gen_random_items(input int count);
        int               added;
        int               kind;
        int               i;
        logic [CW-1:0]    base;
        added = 0;
        while (added < count) begin
            if ($urandom_range(99) < 10) begin
                kind = $urandom_range(2);
                base = (kind == 0) ? 16'h7FFF : (kind == 1) ? 16'h8000 : CW'($urandom);
                for (i = 0; i < NUM_CP; i++) begin
                    if (kind == 2)
                        push_load(i, base + CW'($urandom_range(511)), pick_coord(),
                                  CW'($urandom));
                    else
                        push_load(i, base, base, base);
                end
                for (i = 0; i < 4; i++)
                    push_eval($urandom_range(63), $urandom_range(63));
                added += NUM_CP + 4;
            end else begin
                if ($urandom_range(99) < 45)
                    push_load($urandom_range(NUM_CP-1), pick_coord(), pick_coord(),
                              pick_coord());
                else
                    push_eval($urandom_range(63), $urandom_range(63));
                added++;
            end
        end
    endtask

    // Wait until every item is sent and every surface point is back
    task automatic wait_idle();
        while (pending_cmds.size() > 0 || s_tvalid || expected_points.size() > 0)
            @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);
    endtask

    task automatic write_grid_step(input logic [STEP_W-1:0] value);
        @(posedge aclk);
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        do
            @(posedge aclk);
        while (!cfg_ready);
        step_reg = value;
        cfg_valid <= 1'b0;
    endtask

    // Input driver: sends queued items, updates the predictor on each transaction
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                if (bus_cmd.op == OP_LOAD) begin
                    cp_x[bus_cmd.slot] = bus_cmd.x;
                    cp_y[bus_cmd.slot] = bus_cmd.y;
                    cp_z[bus_cmd.slot] = bus_cmd.z;
                end else begin
                    expected_points.insert(expected_points.size(),
                                           eval_patch(bus_cmd.row, bus_cmd.col));
                end
            end
            if (!s_tvalid || s_tready) begin
                if (pending_cmds.size() > 0 && $urandom_range(99) >= src_idle_pct) begin
                    bus_cmd = pending_cmds.pop_front();
                    s_tdata  <= {bus_cmd.col, bus_cmd.row, bus_cmd.z, bus_cmd.y,
                                 bus_cmd.x, bus_cmd.slot};
                    s_tuser  <= bus_cmd.op;
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Result monitor with random back-pressure
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_points.size() == 0) begin
                    report_mismatch("surface point with no evaluate pending");
                end else begin
                    want_pt = expected_points.pop_front();
                    if (m_tdata[15:0] !== want_pt.x)
                        report_mismatch($sformatf("surf_x got %0d expected %0d",
                            $signed(m_tdata[15:0]), $signed(want_pt.x)));
                    if (m_tdata[31:16] !== want_pt.y)
                        report_mismatch($sformatf("surf_y got %0d expected %0d",
                            $signed(m_tdata[31:16]), $signed(want_pt.y)));
                    if (m_tdata[47:32] !== want_pt.z)
                        report_mismatch($sformatf("surf_z got %0d expected %0d",
                            $signed(m_tdata[47:32]), $signed(want_pt.z)));
                    if (m_tdata[53:48] !== want_pt.row)
                        report_mismatch($sformatf("out_row got %0d expected %0d",
                            m_tdata[53:48], want_pt.row));
                    if (m_tdata[59:54] !== want_pt.col)
                        report_mismatch($sformatf("out_col got %0d expected %0d",
                            m_tdata[59:54], want_pt.col));
                end
            end
            m_tready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    // Count cycles without any transaction
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)
                || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial begin
        while (quiet_cycles < QUIET_LIMIT)
            @(posedge aclk);
        $display("[%0t] ERROR: no transaction for %0d cycles", $time, QUIET_LIMIT);
        $display("FAILURE");
        $finish;
    end

    // Main sequence
    initial begin
        logic [STEP_W-1:0] step_list [8];
        int                ph;
        int                i;
        step_list = '{16'd0, 16'd32768, 16'd65535, 16'd1, 16'd4681, 16'd1024,
                      16'd0, 16'd2048};
        step_list[6] = STEP_W'($urandom_range(65535, 1));

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: empty grid, extreme control points, parameter at and past 1.0
        push_eval(3, 5);
        push_load(0, 16'h7FFF, 16'h8000, 16'h0000);
        for (i = 1; i < NUM_CP; i++)
            push_load(i, (i % 2) ? 16'h8000 : 16'h7FFF, (i % 3) ? 16'h7FFF : 16'hFFFF,
                      (i % 2) ? 16'h0001 : 16'h8000);
        push_eval(0, 0);
        push_eval(63, 63);
        push_eval(16, 0);
        push_eval(0, 16);
        push_eval(8, 8);
        push_eval(5, 63);
        push_eval(63, 0);
        push_eval(1, 2);
        wait_idle();

        // Random phases, one step setting and one idling mode each
        for (ph = 0; ph < 8; ph++) begin
            case (ph % 4)
                0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
                1: begin src_idle_pct = 60; sink_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  sink_stall_pct = 60; end
                default: begin src_idle_pct = 27; sink_stall_pct = 27; end
            endcase
            write_grid_step(step_list[ph]);
            if (ph == 2) begin
                // sender holds off until the pipeline is fully drained
                gen_random_items(115);
                wait_idle();
                gen_random_items(115);
            end else begin
                gen_random_items(230);
            end
            wait_idle();
        end

        if (err_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

FILE: filelist.f
design/bbp_pkg.sv
design/bbp_weight_unit.sv
design/bbp_mac.sv
design/bicubic_bezier_patch_eval.sv
test/tb_bicubic_bezier_patch_eval.sv
